>>> rtl/core/bpc_pkg.sv
// Shared constants and result codes for the buffer pool with local cache.
package bpc_pkg;

    // Sizes of the two stacks and the bulk move between them
    localparam int POOL_DEPTH  = 1024;
    localparam int LOCAL_DEPTH = 64;
    localparam int BULK_SIZE   = 32;
    localparam int BULK        = (BULK_SIZE > LOCAL_DEPTH) ? LOCAL_DEPTH : BULK_SIZE;
    localparam int POOL_RESET  = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;

    // Widths
    localparam int IDX_W      = 10;
    localparam int CFG_W      = 11;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int LOCAL_AW   = $clog2(LOCAL_DEPTH);
    localparam int TOP_W      = $clog2(POOL_DEPTH + 1);
    localparam int LC_W       = $clog2(LOCAL_DEPTH + 1);
    localparam int STATUS_W   = 2;

    // Request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

endpackage

>>> rtl/core/bpc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module bpc_ram #(
    parameter int DATA_W = 10,
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write the addressed word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/buffer_pool_with_local_cache.sv
// Top level of the buffer pool allocator: controller and both stack memories.
//
// A request is taken when start is high and busy is low; its word appears on
// status and alloc_index for exactly one cycle with done high, and the receiver
// cannot hold it off. A free that fits the local stack, or that is refused,
// is answered in the cycle after it is taken; an allocate served from the local
// stack passes through S_POP for one local RAM read. An allocate that finds the
// local stack empty refills it from the global stack, one entry per cycle
// through the global RAM read port, n = min(global top, BULK) entries in all.
// A free that finds the local stack full moves BULK entries to the global
// stack, one per cycle through the local RAM read port. After reset and after
// every pool_size write the global stack is reloaded by a pass over all
// POOL_DEPTH = 1024 entries, one entry per cycle, during which busy stays high;
// pool_size writes are taken at any time.
module buffer_pool_with_local_cache
    import bpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                start,
    input  logic                func,
    input  logic [IDX_W-1:0]    buf_index,
    output logic                busy,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [IDX_W-1:0]    alloc_index
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_FILL,
        S_FLUSH
    } state_t;

    localparam logic [TOP_W-1:0] POOL_MAX   = TOP_W'(POOL_DEPTH);
    localparam logic [TOP_W-1:0] CLEAR_LAST = TOP_W'(POOL_DEPTH - 1);
    localparam logic [TOP_W-1:0] BULK_TOP   = TOP_W'(BULK);
    localparam logic [LC_W-1:0]  BULK_LC    = LC_W'(BULK);
    localparam logic [LC_W-1:0]  LC_FULL    = LC_W'(LOCAL_DEPTH);
    localparam logic [LC_W-1:0]  LC_SPILL   = LC_W'(LOCAL_DEPTH - BULK);

    state_t                state_reg, state_next;
    logic [TOP_W-1:0]      pool_size_reg, pool_size_next;
    logic [TOP_W-1:0]      gt_reg, gt_next;
    logic [LC_W-1:0]       lc_reg, lc_next;
    logic [TOP_W-1:0]      clr_reg, clr_next;
    logic [LC_W-1:0]       cnt_reg, cnt_next;
    logic [LC_W-1:0]       n_reg, n_next;
    logic [TOP_W-1:0]      base_reg, base_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [IDX_W-1:0]      alloc_index_reg, alloc_index_next;

    // Memory ports
    logic                  g_we;
    logic [POOL_AW-1:0]    g_waddr, g_raddr;
    logic [IDX_W-1:0]      g_wdata, g_rdata;
    logic                  l_we;
    logic [LOCAL_AW-1:0]   l_waddr, l_raddr;
    logic [IDX_W-1:0]      l_wdata, l_rdata;

    // Address arithmetic
    logic [TOP_W-1:0]      fill_addr, flush_addr, cfg_clamped;
    logic [TOP_W:0]        spill_top;
    logic [LC_W-1:0]       pop_addr, spill_addr, cnt_dec, refill_n;

    assign fill_addr   = base_reg + TOP_W'(cnt_reg);
    assign flush_addr  = gt_reg + TOP_W'(cnt_reg) - TOP_W'(1);
    assign spill_top   = (TOP_W+1)'(gt_reg) + (TOP_W+1)'(BULK);
    assign pop_addr    = lc_reg - LC_W'(1);
    assign spill_addr  = LC_SPILL + cnt_reg;
    assign cnt_dec     = cnt_reg - LC_W'(1);
    assign refill_n    = (gt_reg < BULK_TOP) ? LC_W'(gt_reg) : BULK_LC;

    // Clamp a pool size write into 1 .. POOL_DEPTH
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_clamped = TOP_W'(1);
        end
        else if ((CFG_W+TOP_W)'(cfg_wdata) > (CFG_W+TOP_W)'(POOL_MAX))
        begin
            cfg_clamped = POOL_MAX;
        end
        else
        begin
            cfg_clamped = TOP_W'(cfg_wdata);
        end
    end

    // Sequence requests, bulk moves and the reload pass
    always_comb
    begin
        state_next       = state_reg;
        pool_size_next   = pool_size_reg;
        gt_next          = gt_reg;
        lc_next          = lc_reg;
        clr_next         = clr_reg;
        cnt_next         = cnt_reg;
        n_next           = n_reg;
        base_next        = base_reg;
        idx_next         = idx_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        alloc_index_next = alloc_index_reg;

        g_we    = 1'b0;
        g_waddr = clr_reg[POOL_AW-1:0];
        g_wdata = IDX_W'(clr_reg);
        g_raddr = fill_addr[POOL_AW-1:0];
        l_we    = 1'b0;
        l_waddr = lc_reg[LOCAL_AW-1:0];
        l_wdata = buf_index;
        l_raddr = pop_addr[LOCAL_AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // Reload the global stack with entry i = i
                g_we     = 1'b1;
                clr_next = clr_reg + TOP_W'(1);
                if (clr_reg == CLEAR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_ALLOC)
                    begin
                        if (lc_reg != '0)
                        begin
                            state_next = S_POP;
                        end
                        else if (gt_reg == '0)
                        begin
                            done_next        = 1'b1;
                            status_next      = ST_EMPTY;
                            alloc_index_next = '0;
                        end
                        else
                        begin
                            n_next     = refill_n;
                            base_next  = gt_reg - TOP_W'(refill_n);
                            cnt_next   = '0;
                            state_next = S_FILL;
                        end
                    end
                    else if (TOP_W'(buf_index) >= pool_size_reg)
                    begin
                        done_next        = 1'b1;
                        status_next      = ST_RANGE;
                        alloc_index_next = '0;
                    end
                    else if (lc_reg < LC_FULL)
                    begin
                        // Push straight onto the local stack
                        l_we             = 1'b1;
                        lc_next          = lc_reg + LC_W'(1);
                        done_next        = 1'b1;
                        status_next      = ST_OK;
                        alloc_index_next = '0;
                    end
                    else if (spill_top > (TOP_W+1)'(pool_size_reg))
                    begin
                        done_next        = 1'b1;
                        status_next      = ST_OVERFLOW;
                        alloc_index_next = '0;
                    end
                    else
                    begin
                        idx_next   = buf_index;
                        cnt_next   = '0;
                        state_next = S_FLUSH;
                    end
                end
            end

            S_POP:
            begin
                // Hand out the local top
                lc_next          = pop_addr;
                done_next        = 1'b1;
                status_next      = ST_OK;
                alloc_index_next = l_rdata;
                state_next       = S_IDLE;
            end

            S_FILL:
            begin
                // Stream global entries into the bottom of the local stack
                if (cnt_reg != '0)
                begin
                    l_we    = 1'b1;
                    l_waddr = cnt_dec[LOCAL_AW-1:0];
                    l_wdata = g_rdata;
                end
                cnt_next = cnt_reg + LC_W'(1);
                if (cnt_reg == n_reg)
                begin
                    lc_next          = n_reg - LC_W'(1);
                    gt_next          = base_reg;
                    done_next        = 1'b1;
                    status_next      = ST_OK;
                    alloc_index_next = g_rdata;
                    state_next       = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                // Stream the top local entries onto the global stack
                l_raddr = spill_addr[LOCAL_AW-1:0];
                if (cnt_reg != '0)
                begin
                    g_we    = 1'b1;
                    g_waddr = flush_addr[POOL_AW-1:0];
                    g_wdata = l_rdata;
                end
                cnt_next = cnt_reg + LC_W'(1);
                if (cnt_reg == BULK_LC)
                begin
                    l_we             = 1'b1;
                    l_waddr          = LC_SPILL[LOCAL_AW-1:0];
                    l_wdata          = idx_reg;
                    lc_next          = LC_SPILL + LC_W'(1);
                    gt_next          = gt_reg + BULK_TOP;
                    done_next        = 1'b1;
                    status_next      = ST_OK;
                    alloc_index_next = '0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A pool size write reloads everything
        if (cfg_we)
        begin
            pool_size_next = cfg_clamped;
            gt_next        = cfg_clamped;
            lc_next        = '0;
            clr_next       = '0;
            state_next     = S_CLEAR;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pool_size_reg <= TOP_W'(POOL_RESET);
            gt_reg        <= TOP_W'(POOL_RESET);
            lc_reg        <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_size_reg <= pool_size_next;
            gt_reg        <= gt_next;
            lc_reg        <= lc_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        base_reg        <= base_next;
        idx_reg         <= idx_next;
        status_reg      <= status_next;
        alloc_index_reg <= alloc_index_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign alloc_index = alloc_index_reg;

    bpc_ram #(
        .DATA_W (IDX_W),
        .ADDR_W (POOL_AW),
        .DEPTH  (POOL_DEPTH)
    ) u_global_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    bpc_ram #(
        .DATA_W (IDX_W),
        .ADDR_W (LOCAL_AW),
        .DEPTH  (LOCAL_DEPTH)
    ) u_local_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

endmodule
